@@ hw/rtl/hbd_pkg.sv @@
// Shared types, match patterns and byte-matcher functions for the HTTP body deframer.
// No dependencies; used by http_body_deframer_core and the testbench.
`default_nettype none
package hbd_pkg;

  localparam int LEN_PAT_SIZE = 18;
  localparam int END_PAT_SIZE = 4;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // CR LF "Content-Length: "
  localparam logic [7:0] LEN_PAT [LEN_PAT_SIZE] = '{
    8'h0d, 8'h0a, 8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74,
    8'h2d, 8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
  };

  // CR LF CR LF
  localparam logic [7:0] END_PAT [END_PAT_SIZE] = '{8'h0d, 8'h0a, 8'h0d, 8'h0a};

  typedef enum logic [3:0] {
    PH_SEARCH_LEN = 4'b0001,
    PH_DIGITS     = 4'b0010,
    PH_SEARCH_END = 4'b0100,
    PH_PAYLOAD    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [4:0] pos;
    logic       hit;
  } match_t;

  // Advance the length-pattern matcher by one byte; a mismatching CR restarts at one.
  function automatic match_t feed_len(logic [4:0] pos_in, logic [7:0] b);
    logic [4:0] pos;
    match_t     r;
    pos = (pos_in >= 5'(LEN_PAT_SIZE)) ? 5'd0 : pos_in;
    if (b == LEN_PAT[pos]) begin
      pos = pos + 5'd1;
    end else begin
      pos = (b == CH_CR) ? 5'd1 : 5'd0;
    end
    if (pos >= 5'(LEN_PAT_SIZE)) begin
      r.pos = 5'd0;
      r.hit = 1'b1;
    end else begin
      r.pos = pos;
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Advance the header-end matcher by one byte.
  function automatic match_t feed_end(logic [2:0] pos_in, logic [7:0] b);
    logic [2:0] pos;
    match_t     r;
    pos = (pos_in >= 3'(END_PAT_SIZE)) ? 3'd0 : pos_in;
    if (b == END_PAT[pos[1:0]]) begin
      pos = pos + 3'd1;
    end else begin
      pos = (b == CH_CR) ? 3'd1 : 3'd0;
    end
    if (pos >= 3'(END_PAT_SIZE)) begin
      r.pos = 5'd0;
      r.hit = 1'b1;
    end else begin
      r.pos = {2'b00, pos};
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hbd_acc.sv @@
// Saturating decimal accumulator: value * 10 + digit, clamped at all ones.
// Depends on nothing beyond its parameter.
`default_nettype none
module hbd_acc #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic [LENGTH_BITS-1:0] value,
  input  wire logic [3:0]             digit,
  output logic      [LENGTH_BITS-1:0] result
);

  logic [LENGTH_BITS+3:0] wide;
  logic [LENGTH_BITS+3:0] wide_value;

  assign wide_value = {4'b0000, value};
  // times ten as shift-and-add, four guard bits catch the overflow
  assign wide = (wide_value << 3) + (wide_value << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign result = (|wide[LENGTH_BITS+3:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                      : wide[LENGTH_BITS-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/http_body_deframer_core.sv @@
// HTTP body deframer top level: header matchers, length capture, body pass-through.
// Depends on hbd_pkg and hbd_acc.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   data     | data_valid / data_ready    | data_byte
//   payload  | payload_valid / payload_ready | payload_byte, last_of_message
//
// One word per cycle: each accepted byte updates the matcher and counter state at its
// accepting edge; a body byte is loaded into the output register at that same edge and
// is offered from the next cycle.
// data_ready is high whenever the output register is empty or being drained.
// A stalled output register holds its word and holds off the next input word.
// Reset (rst, synchronous) returns to the length-field search with an empty output.
`default_nettype none
module http_body_deframer_core #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       data_valid,
  output logic            data_ready,
  input  wire logic [7:0] data_byte,
  output logic            payload_valid,
  input  wire logic       payload_ready,
  output logic      [7:0] payload_byte,
  output logic            last_of_message
);

  hbd_pkg::phase_t        phase, phase_next;
  logic [4:0]             pattern_position, pattern_position_next;
  logic [2:0]             header_end_position, header_end_position_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic                   digit_seen, digit_seen_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;

  logic                   accept;
  logic                   is_digit;
  logic [LENGTH_BITS-1:0] acc_value;
  logic [LENGTH_BITS-1:0] remaining_dec;
  logic                   emit;
  logic                   emit_last;
  hbd_pkg::match_t        len_m;
  hbd_pkg::match_t        end_m;

  assign data_ready = !payload_valid || payload_ready;
  assign accept     = data_valid && data_ready;
  assign is_digit   = (data_byte >= hbd_pkg::CH_ZERO) && (data_byte <= hbd_pkg::CH_NINE);
  assign remaining_dec = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : '0;

  hbd_acc #(.LENGTH_BITS(LENGTH_BITS)) u_acc (
    .value  (length_value),
    .digit  (data_byte[3:0]),
    .result (acc_value)
  );

  always_comb begin
    phase_next               = phase;
    pattern_position_next    = pattern_position;
    header_end_position_next = header_end_position;
    length_value_next        = length_value;
    digit_seen_next          = digit_seen;
    bytes_remaining_next     = bytes_remaining;
    emit                     = 1'b0;
    emit_last                = 1'b0;
    len_m                    = hbd_pkg::feed_len(pattern_position, data_byte);
    end_m                    = hbd_pkg::feed_end(header_end_position, data_byte);
    case (phase)
      hbd_pkg::PH_SEARCH_LEN: begin
        pattern_position_next = len_m.pos;
        if (len_m.hit) begin
          phase_next        = hbd_pkg::PH_DIGITS;
          length_value_next = '0;
          digit_seen_next   = 1'b0;
        end
      end
      hbd_pkg::PH_DIGITS: begin
        if (is_digit) begin
          length_value_next = acc_value;
          digit_seen_next   = 1'b1;
        end else if (!digit_seen) begin
          // no digits: restart the search with this byte
          len_m                    = hbd_pkg::feed_len(5'd0, data_byte);
          pattern_position_next    = len_m.pos;
          header_end_position_next = 3'd0;
          phase_next               = len_m.hit ? hbd_pkg::PH_DIGITS : hbd_pkg::PH_SEARCH_LEN;
          if (len_m.hit) begin
            length_value_next = '0;
            digit_seen_next   = 1'b0;
          end
        end else begin
          // byte ending the digits opens the header-end match
          end_m                    = hbd_pkg::feed_end(3'd0, data_byte);
          header_end_position_next = end_m.pos[2:0];
          phase_next               = hbd_pkg::PH_SEARCH_END;
          if (end_m.hit) begin
            bytes_remaining_next = length_value;
            if (length_value == '0) begin
              phase_next               = hbd_pkg::PH_SEARCH_LEN;
              pattern_position_next    = 5'd0;
              header_end_position_next = 3'd0;
            end else begin
              phase_next = hbd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      hbd_pkg::PH_SEARCH_END: begin
        header_end_position_next = end_m.pos[2:0];
        if (end_m.hit) begin
          bytes_remaining_next = length_value;
          if (length_value == '0) begin
            phase_next               = hbd_pkg::PH_SEARCH_LEN;
            pattern_position_next    = 5'd0;
            header_end_position_next = 3'd0;
          end else begin
            phase_next = hbd_pkg::PH_PAYLOAD;
          end
        end
      end
      hbd_pkg::PH_PAYLOAD: begin
        emit                 = 1'b1;
        emit_last            = (remaining_dec == '0);
        bytes_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          phase_next               = hbd_pkg::PH_SEARCH_LEN;
          pattern_position_next    = 5'd0;
          header_end_position_next = 3'd0;
        end
      end
      default: begin
        phase_next = hbd_pkg::PH_SEARCH_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= hbd_pkg::PH_SEARCH_LEN;
      pattern_position    <= 5'd0;
      header_end_position <= 3'd0;
      length_value        <= '0;
      digit_seen          <= 1'b0;
      bytes_remaining     <= '0;
    end else if (accept) begin
      phase               <= phase_next;
      pattern_position    <= pattern_position_next;
      header_end_position <= header_end_position_next;
      length_value        <= length_value_next;
      digit_seen          <= digit_seen_next;
      bytes_remaining     <= bytes_remaining_next;
    end
  end

  // output register: load on an accepted body byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_valid <= 1'b0;
    end else if (data_ready) begin
      payload_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      payload_byte    <= data_byte;
      last_of_message <= emit_last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hbd_checker.sv @@
// Port-level checker for http_body_deframer_core, attached by bind below.
// Depends only on the top level's ports.
`default_nettype none
module hbd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       data_valid,
  input wire logic       data_ready,
  input wire logic [7:0] data_byte,
  input wire logic       payload_valid,
  input wire logic       payload_ready,
  input wire logic [7:0] payload_byte,
  input wire logic       last_of_message
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    payload_valid && !payload_ready |=> payload_valid && $stable(payload_byte)
      && $stable(last_of_message))
    else $error("payload word changed while stalled");

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_ready |=> data_valid && $stable(data_byte))
    else $error("input word changed while waiting");

  // input is taken whenever the output register is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    data_ready == (!payload_valid || payload_ready))
    else $error("data_ready does not follow output register space");

  // a new output word needs an input word accepted just before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    payload_valid && !$past(payload_valid && !payload_ready) |->
      $past(data_valid && data_ready))
    else $error("payload word without an accepted input word");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !payload_valid)
    else $error("payload_valid after reset");

endmodule

bind http_body_deframer_core hbd_checker u_hbd_checker (
  .clk             (clk),
  .rst             (rst),
  .data_valid      (data_valid),
  .data_ready      (data_ready),
  .data_byte       (data_byte),
  .payload_valid   (payload_valid),
  .payload_ready   (payload_ready),
  .payload_byte    (payload_byte),
  .last_of_message (last_of_message)
);
`default_nettype wire

@@ tb/http_body_deframer_checker.sv @@
// Checker for the HTTP body deframer: follows both channels, predicts body words.
// Depends on hbd_pkg for the match patterns, the character codes and phase_t.
`default_nettype none
module http_body_deframer_checker #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       data_valid,
  input  wire logic       data_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       payload_valid,
  input  wire logic       payload_ready,
  input  wire logic [7:0] payload_byte,
  input  wire logic       last_of_message,
  output int              fail_count,
  output int              words_due
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_word_t;

  localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

  body_word_t             body_words_due[$];
  body_word_t             got_word;
  hbd_pkg::phase_t        phase_q;
  logic [4:0]             len_match;
  logic [2:0]             term_match;
  logic [LENGTH_BITS-1:0] content_len;
  logic [LENGTH_BITS-1:0] body_left;
  logic                   have_digit;

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  // Advance the "CR LF Content-Length: " search; a mismatching CR counts as a new start.
  function automatic bit len_match_step(logic [7:0] b);
    int p;
    p = (len_match >= hbd_pkg::LEN_PAT_SIZE) ? 0 : int'(len_match);
    if (b == hbd_pkg::LEN_PAT[p]) begin
      p++;
    end else begin
      p = (b == hbd_pkg::CH_CR) ? 1 : 0;
    end
    if (p >= hbd_pkg::LEN_PAT_SIZE) begin
      len_match = '0;
      return 1'b1;
    end
    len_match = 5'(p);
    return 1'b0;
  endfunction

  function automatic bit term_match_step(logic [7:0] b);
    int p;
    p = (term_match >= hbd_pkg::END_PAT_SIZE) ? 0 : int'(term_match);
    if (b == hbd_pkg::END_PAT[p]) begin
      p++;
    end else begin
      p = (b == hbd_pkg::CH_CR) ? 1 : 0;
    end
    if (p >= hbd_pkg::END_PAT_SIZE) begin
      term_match = '0;
      return 1'b1;
    end
    term_match = 3'(p);
    return 1'b0;
  endfunction

  function automatic void restart_search();
    phase_q    = hbd_pkg::PH_SEARCH_LEN;
    len_match  = '0;
    term_match = '0;
  endfunction

  function automatic void start_digits();
    phase_q     = hbd_pkg::PH_DIGITS;
    content_len = '0;
    have_digit  = 1'b0;
  endfunction

  function automatic void header_end_byte(logic [7:0] b);
    if (term_match_step(b)) begin
      body_left = content_len;
      if (body_left == '0) begin
        restart_search();
      end else begin
        phase_q = hbd_pkg::PH_PAYLOAD;
      end
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [LENGTH_BITS-1:0] d;
    d = '0;
    case (phase_q)
      hbd_pkg::PH_SEARCH_LEN: begin
        if (len_match_step(b)) start_digits();
      end
      hbd_pkg::PH_DIGITS: begin
        if (b >= hbd_pkg::CH_ZERO && b <= hbd_pkg::CH_NINE) begin
          d[3:0] = b[3:0];
          // saturate at the top of the length range
          if (content_len > (LEN_SAT - d) / 10) begin
            content_len = LEN_SAT;
          end else begin
            content_len = content_len * 10 + d;
          end
          have_digit = 1'b1;
        end else if (!have_digit) begin
          // no digit: the byte goes back to the length search
          restart_search();
          if (len_match_step(b)) start_digits();
        end else begin
          // the byte ending the digits is the first one the terminator search sees
          phase_q    = hbd_pkg::PH_SEARCH_END;
          term_match = '0;
          header_end_byte(b);
        end
      end
      hbd_pkg::PH_SEARCH_END: begin
        header_end_byte(b);
      end
      default: begin
        if (body_left != '0) body_left = body_left - 1'b1;
        body_words_due.push_back('{data: b, last: (body_left == '0)});
        if (body_left == '0) restart_search();
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [7:0] exp_b, logic exp_l);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: expected byte %02h last %0b, got byte %02h last %0b", what, exp_b,
               exp_l, payload_byte, last_of_message);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      body_words_due.delete();
      content_len = '0;
      body_left   = '0;
      have_digit  = 1'b0;
      restart_search();
    end else begin
      // drain first: a body word leaving now never stems from the byte entering now
      if (payload_valid && payload_ready) begin
        if (body_words_due.size() == 0) begin
          note_mismatch("unexpected body word", 8'hxx, 1'bx);
        end else begin
          got_word = body_words_due.pop_front();
          if (payload_byte !== got_word.data || last_of_message !== got_word.last) begin
            note_mismatch("body word mismatch", got_word.data, got_word.last);
          end
        end
      end
      if (data_valid && data_ready) predict_byte(data_byte);
    end
    words_due <= body_words_due.size();
  end

endmodule
`default_nettype wire

@@ tb/http_body_deframer_core_test.sv @@
// Top of the HTTP body deframer test: clock, reset, byte stimulus, output stalls, verdict.
// Depends on hbd_pkg, http_body_deframer_core and http_body_deframer_checker.
`default_nettype none
module http_body_deframer_core_test;

  localparam int LENGTH_BITS    = 32;
  localparam int TOTAL_BYTES    = 500;
  localparam int WATCHDOG_LIMIT = 1000;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       data_valid    = 1'b0;
  logic [7:0] data_byte     = 8'h00;
  logic       payload_ready = 1'b0;
  wire        data_ready;
  wire        payload_valid;
  wire  [7:0] payload_byte;
  wire        last_of_message;

  int fail_count;
  int words_due;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  int ready_hold  = 0;
  bit gaps_on     = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  http_body_deframer_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .payload_valid  (payload_valid),
    .payload_ready  (payload_ready),
    .payload_byte   (payload_byte),
    .last_of_message(last_of_message)
  );

  http_body_deframer_checker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .payload_valid  (payload_valid),
    .payload_ready  (payload_ready),
    .payload_byte   (payload_byte),
    .last_of_message(last_of_message),
    .fail_count     (fail_count),
    .words_due      (words_due)
  );

  // mostly short pauses, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      payload_ready <= 1'b0;
      ready_hold    <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (payload_ready) begin
      payload_ready <= 1'b0;
      ready_hold    <= idle_length() - 1;
    end else begin
      payload_ready <= 1'b1;
      ready_hold    <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (payload_valid && payload_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Hold valid across back-to-back words; drop it only when a gap starts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) >= 65) ? idle_length() : 0;
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_ready !== 1'b1) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_pattern(input int count);
    for (int i = 0; i < count; i++) send_byte(hbd_pkg::LEN_PAT[i]);
  endtask

  task automatic send_decimal(input longint unsigned value, input int zeros);
    string s;
    s = $sformatf("%0d", value);
    repeat (zeros) send_byte(hbd_pkg::CH_ZERO);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_terminator();
    send_byte(hbd_pkg::CH_CR);
    send_byte(hbd_pkg::CH_LF);
    send_byte(hbd_pkg::CH_CR);
    send_byte(hbd_pkg::CH_LF);
  endtask

  // Header noise: never a digit, rich in CR, LF and pattern starts.
  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1:    b = hbd_pkg::CH_CR;
        2:       b = hbd_pkg::CH_LF;
        3:       b = hbd_pkg::LEN_PAT[2];
        4:       b = hbd_pkg::LEN_PAT[16];
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b >= hbd_pkg::CH_ZERO && b <= hbd_pkg::CH_NINE) b[6] = 1'b1;
      send_byte(b);
    end
  endtask

  task automatic wait_for_drain();
    data_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  initial begin
    int  kind;
    int  sel;
    int  len;
    bit  drained_once;
    drained_once = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // stray CR before the pattern, two-byte body at both byte extremes
    send_byte(hbd_pkg::CH_CR);
    send_pattern(hbd_pkg::LEN_PAT_SIZE);
    send_decimal(2, 0);
    send_terminator();
    send_byte(8'h00);
    send_byte(8'hff);

    while (bytes_sent < TOTAL_BYTES) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 75) begin
        sel = $urandom_range(0, 99);
        len = (sel < 15) ? 0 : (sel < 85) ? $urandom_range(1, 6) :
              (sel < 95) ? $urandom_range(7, 30) : $urandom_range(31, 60);
        send_noise($urandom_range(0, 3));
        send_pattern(hbd_pkg::LEN_PAT_SIZE);
        send_decimal(len, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 3));
        send_terminator();
        repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        // full pattern, then no digit
        send_pattern(hbd_pkg::LEN_PAT_SIZE);
        send_noise(1);
      end else if (kind < 95) begin
        send_pattern($urandom_range(1, hbd_pkg::LEN_PAT_SIZE - 1));
        send_noise($urandom_range(1, 2));
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if ((!drained_once && bytes_sent > TOTAL_BYTES / 2) || $urandom_range(0, 9) == 0) begin
        wait_for_drain();
        drained_once = 1'b1;
      end
    end

    // Saturating length: the body never completes, so keep this last.
    gaps_on = 1'b1;
    send_pattern(hbd_pkg::LEN_PAT_SIZE);
    send_decimal(64'd99999999999, 0);
    send_terminator();
    repeat (6) send_byte(8'($urandom_range(0, 255)));

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
